// ===== rtl/core/atdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atdf_pkg
// Shared types and constants of the associative tag directory.
// ----------------------------------------------------------------------------
package atdf_pkg;

    localparam int unsigned ENTRIES = 16;
    localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned SLOT_W  = 4;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_idx IDX_LAST = t_idx'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // per-cycle controls from the sequencer
    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic wr_en;
        logic out_load;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/atdf_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atdf_ifs
// Request and response channels of the tag directory, valid/ready handshake.
// ----------------------------------------------------------------------------
interface atdf_req_if;
    logic            valid;
    logic            ready;
    atdf_pkg::t_id   request_id;
    logic            fill_ok;

    modport source (output valid, output request_id, output fill_ok, input ready);
    modport sink   (input valid, input request_id, input fill_ok, output ready);
endinterface

interface atdf_rsp_if;
    logic            valid;
    logic            ready;
    logic            hit;
    atdf_pkg::t_slot slot;
    logic            evict_valid;
    atdf_pkg::t_id   evicted_id;
    logic            failed;

    modport source (output valid, output hit, output slot, output evict_valid,
                    output evicted_id, output failed, input ready);
    modport sink   (input valid, input hit, input slot, input evict_valid,
                    input evicted_id, input failed, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/assoc_tag_directory_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// assoc_tag_directory_fifo
// Tag directory of a small fully associative cache with first-in first-out
// replacement; tags in a RAM scanned one entry a cycle, valid bits in flops.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | beat
//  i_req    | in  | request_id, fill_ok                            | valid & ready
//  o_rsp    | out | hit, slot, evict_valid, evicted_id, failed     | valid & ready
//
// one request at a time: a miss scans all ENTRIES tags, a hit on slot k ends the
// scan at that slot; the single RAM read port walks one tag a cycle.
// results sit in an output register, so a new request is taken while one waits.
// reset clears the valid bits and the replacement pointer; no clearing pass.
// a stalled output only holds the finish step, the scan itself runs on.
// ----------------------------------------------------------------------------
module assoc_tag_directory_fifo (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    atdf_req_if.sink  i_req,
    atdf_rsp_if.source o_rsp
);
    import atdf_pkg::*;

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;

    logic [ENTRIES-1:0] r_valid;
    t_idx   r_ptr;
    t_idx   n_ptr;
    t_idx   r_addr;
    logic   r_last_issued;
    t_idx   r_cmp_idx;
    logic   r_cmp_valid;
    t_id    r_id;
    logic   r_fill_ok;
    logic   r_hit;
    t_idx   r_hit_idx;
    logic   r_ev_v;
    t_id    r_ev_id;
    t_id    rd_data;
    logic   match;
    logic   scan_end;
    logic   ev_out;

    logic   r_out_valid;
    logic   r_o_hit;
    t_slot  r_o_slot;
    logic   r_o_ev;
    t_id    r_o_ev_id;
    logic   r_o_failed;

    atdf_ram #(
        .WIDTH (ID_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (ctrl.wr_en),
        .i_waddr(r_ptr),
        .i_wdata(r_id),
        .i_re   (ctrl.rd_en),
        .i_raddr(r_addr),
        .o_rdata(rd_data)
    );

    assign match    = r_cmp_valid && r_valid[r_cmp_idx] && (rd_data == r_id);
    assign scan_end = r_cmp_valid && (match || (r_cmp_idx == IDX_LAST));
    assign n_ptr    = (r_ptr == IDX_LAST) ? '0 : r_ptr + t_idx'(1);
    assign ev_out   = !r_hit && r_fill_ok && r_ev_v;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // controls
    always_comb begin
        ctrl = '0;
        case (r_state)
            S_IDLE: ctrl.in_ready = 1'b1;
            // stop issuing reads once the scan has ended
            S_SCAN: ctrl.rd_en    = !r_last_issued && !scan_end;
            S_DONE: begin
                ctrl.out_load = !r_out_valid || o_rsp.ready;
                ctrl.wr_en    = ctrl.out_load && !r_hit && r_fill_ok;
            end
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_ptr         <= '0;
            r_cmp_valid   <= 1'b0;
            r_last_issued <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (ctrl.in_ready && i_req.valid) begin
                r_addr        <= '0;
                r_last_issued <= 1'b0;
                r_id          <= i_req.request_id;
                r_fill_ok     <= i_req.fill_ok;
                r_hit         <= 1'b0;
                r_ev_v        <= 1'b0;
            end

            r_cmp_valid <= ctrl.rd_en;
            if (ctrl.rd_en) begin
                r_cmp_idx     <= r_addr;
                r_addr        <= r_addr + t_idx'(1);
                r_last_issued <= (r_addr == IDX_LAST);
            end

            // pick up the tag under the replacement pointer as it streams by
            if (r_cmp_valid && (r_cmp_idx == r_ptr)) begin
                r_ev_v  <= r_valid[r_ptr];
                r_ev_id <= rd_data;
            end
            if (match && r_state == S_SCAN) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end

            if (ctrl.wr_en) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= n_ptr;
            end

            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
                r_o_hit     <= r_hit;
                r_o_slot    <= r_hit ? t_slot'(r_hit_idx) : t_slot'(r_ptr);
                r_o_ev      <= ev_out;
                r_o_ev_id   <= ev_out ? r_ev_id : '0;
                r_o_failed  <= !r_hit && !r_fill_ok;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready       = ctrl.in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.slot        = r_o_slot;
    assign o_rsp.evict_valid = r_o_ev;
    assign o_rsp.evicted_id  = r_o_ev_id;
    assign o_rsp.failed      = r_o_failed;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= IDX_LAST)
        else $error("replacement pointer out of range");

    a_write_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.wr_en |-> (r_state == S_DONE && !r_hit && r_fill_ok))
        else $error("tag write outside a successful miss");

    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.wr_en |=> r_valid[$past(r_ptr)])
        else $error("installed slot not marked valid");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> (!o_rsp.evict_valid && !o_rsp.failed))
        else $error("hit reports eviction or failure");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (r_state == S_SCAN))
        else $error("tag compare outside scan");

endmodule

`default_nettype wire

// ===== rtl/core/atdf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atdf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module atdf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== dv/assoc_tag_directory_fifo_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// assoc_tag_directory_fifo_tb
// Self-checking bench for the tag directory: a scoreboard keeps its own tag
// store, valid bits and fifo pointer, predicts each lookup as the request
// beat is taken, and compares every response beat with the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic            hit;
    atdf_pkg::t_slot slot;
    logic            evict_valid;
    atdf_pkg::t_id   evicted_id;
    logic            failed;
} lookup_result_t;

class directory_scoreboard;
    atdf_pkg::t_id  tags [atdf_pkg::ENTRIES];
    bit             present [atdf_pkg::ENTRIES];
    atdf_pkg::t_idx fill_ptr;
    lookup_result_t pending_lookups [$];
    int unsigned    failures;

    function new();
        foreach (present[i]) begin
            present[i] = 1'b0;
            tags[i]    = '0;
        end
        fill_ptr = '0;
        failures = 0;
    endfunction

    // lookup, then on a good miss replace the oldest slot
    function lookup_result_t predict_lookup(atdf_pkg::t_id id, logic ok);
        lookup_result_t res;
        res = '0;
        for (int i = 0; i < atdf_pkg::ENTRIES; i++) begin
            if (present[i] && tags[i] == id) begin
                res.hit  = 1'b1;
                res.slot = atdf_pkg::t_slot'(i);
                return res;
            end
        end
        res.slot = atdf_pkg::t_slot'(fill_ptr);
        if (!ok) begin
            res.failed = 1'b1;
            return res;
        end
        if (present[fill_ptr]) begin
            res.evict_valid = 1'b1;
            res.evicted_id  = tags[fill_ptr];
        end
        tags[fill_ptr]    = id;
        present[fill_ptr] = 1'b1;
        fill_ptr = (fill_ptr == atdf_pkg::IDX_LAST) ? '0 : fill_ptr + 1'b1;
        return res;
    endfunction

    function void note_request(atdf_pkg::t_id id, logic ok);
        pending_lookups.push_back(predict_lookup(id, ok));
    endfunction

    function void check_response(lookup_result_t got);
        lookup_result_t exp;
        if (pending_lookups.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected response beat: hit=%0b slot=%0d ev=%0b evid=%h fail=%0b",
                         got.hit, got.slot, got.evict_valid, got.evicted_id, got.failed);
            return;
        end
        exp = pending_lookups.pop_front();
        if (got.hit !== exp.hit || got.slot !== exp.slot ||
            got.evict_valid !== exp.evict_valid || got.evicted_id !== exp.evicted_id ||
            got.failed !== exp.failed) begin
            failures++;
            if (failures <= 10)
                $display("mismatch: exp hit=%0b slot=%0d ev=%0b evid=%h fail=%0b | got hit=%0b slot=%0d ev=%0b evid=%h fail=%0b",
                         exp.hit, exp.slot, exp.evict_valid, exp.evicted_id, exp.failed,
                         got.hit, got.slot, got.evict_valid, got.evicted_id, got.failed);
        end
    endfunction

    function int pending();
        return pending_lookups.size();
    endfunction
endclass

module assoc_tag_directory_fifo_tb;

    localparam int unsigned RANDOM_ITEMS    = 2000;
    localparam int unsigned POOL_DEPTH      = 48;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    atdf_req_if req_ch ();
    atdf_rsp_if rsp_ch ();

    assoc_tag_directory_fifo u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    directory_scoreboard sb = new();

    bit            hold_off_req = 1'b0;
    int unsigned   send_quiet   = 0;
    int unsigned   recv_quiet   = 0;
    int unsigned   idle_cycles  = 0;
    atdf_pkg::t_id id_pool [POOL_DEPTH];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, a few long, and now and then a stretch with none
    function automatic int unsigned draw_gap(inout int unsigned quiet_left);
        int unsigned r;
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0) begin
            quiet_left = $urandom_range(30, 150);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_request(input atdf_pkg::t_id id, input logic ok,
                                input int unsigned gap);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.request_id <= id;
        req_ch.fill_ok    <= ok;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(id, ok);
    endtask

    task automatic send_pool_request(input int unsigned pool_size, input int unsigned gap);
        atdf_pkg::t_id id;
        logic          ok;
        if ($urandom_range(0, 99) < 85)
            id = id_pool[$urandom_range(0, pool_size - 1)];
        else
            id = $urandom;
        ok = ($urandom_range(0, 99) < 80);
        send_request(id, ok, gap);
    endtask

    // response beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response('{rsp_ch.hit, rsp_ch.slot, rsp_ch.evict_valid,
                                rsp_ch.evicted_id, rsp_ch.failed});
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // response ready, with random stalls and one long hold-off on request
    initial begin
        int unsigned stall_left;
        int unsigned g;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                g = draw_gap(recv_quiet);
                if (g == 0) begin
                    rsp_ch.ready <= 1'b1;
                end else begin
                    stall_left = g - 1;
                    rsp_ch.ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        int unsigned pool_size;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.request_id <= '0;
        req_ch.fill_ok    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // failed fill on an empty directory, then fill slot 0, then hit with fill_ok low
        send_request(32'h0000_0000, 1'b0, 0);
        send_request(32'h0000_0000, 1'b1, draw_gap(send_quiet));
        send_request(32'h0000_0000, 1'b0, 0);
        send_request(32'hFFFF_FFFF, 1'b1, draw_gap(send_quiet));
        for (int i = 2; i < atdf_pkg::ENTRIES; i++)
            send_request(32'h5A5A_5A00 | i, 1'b1, draw_gap(send_quiet));
        // hit on the last slot, failed fill when full, evict oldest, hit with fill_ok low, evict next
        send_request(32'h5A5A_5A00 | (atdf_pkg::ENTRIES - 1), 1'b1, 0);
        send_request(32'h1234_5678, 1'b0, 0);
        send_request(32'h1234_5678, 1'b1, draw_gap(send_quiet));
        send_request(32'hFFFF_FFFF, 1'b0, 0);
        send_request(32'h0000_0000, 1'b1, 0);

        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_DEPTH; i++)
            id_pool[i] = $urandom;

        // back-to-back requests while the response side holds off
        hold_off_req = 1'b1;
        pool_size = 24;
        for (int i = 0; i < 12; i++)
            send_pool_request(pool_size, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0)
                pool_size = $urandom_range(4, POOL_DEPTH);
            if ($urandom_range(0, 19) == 0)
                id_pool[$urandom_range(2, POOL_DEPTH - 1)] = $urandom;
            send_pool_request(pool_size, draw_gap(send_quiet));
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
